/* rtl/acs_pkg.sv */
`timescale 1ns / 1ps
package acs_pkg;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_WAIT,
      ST_SC_RD,
      ST_SC_CHK,
      ST_NORM,
      ST_SQ,
      ST_SQW,
      ST_EXP,
      ST_EXPW,
      ST_RT,
      ST_RTW,
      ST_G,
      ST_GW,
      ST_SC_ADD,
      ST_DECIDE,
      ST_T1,
      ST_T2,
      ST_T3,
      ST_RL_RD,
      ST_RL_CHK,
      ST_U_RD,
      ST_U_GET,
      ST_U_M1,
      ST_U_M2,
      ST_U_M3,
      ST_U_M4,
      ST_U_M5,
      ST_U_WR,
      ST_RESP
   } state_type;

   localparam logic [1:0] FN_LOAD  = 2'd0;
   localparam logic [1:0] FN_START = 2'd1;
   localparam logic [1:0] FN_STEP  = 2'd2;
   localparam logic [1:0] FN_READ  = 2'd3;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NONE    = 2'd1;
   localparam logic [1:0] STAT_NOSTART = 2'd2;

   localparam logic [2:0] CSR_GREEDY = 3'd0;
   localparam logic [2:0] CSR_EVAP   = 3'd1;
   localparam logic [2:0] CSR_BETA   = 3'd2;
   localparam logic [2:0] CSR_TAU0   = 3'd3;
   localparam logic [2:0] CSR_CITIES = 3'd4;

   localparam logic [15:0] RST_GREEDY = 16'd0;
   localparam logic [15:0] RST_EVAP   = 16'd6554;
   localparam logic [7:0]  RST_BETA   = 8'd32;
   localparam logic [31:0] RST_TAU0   = 32'd65536;
   localparam logic [6:0]  RST_CITIES = 7'd64;

   localparam logic [21:0] LEN_MAX = 22'h3F_FFFF;
   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bit_v;
      x     = x_in;
      res   = 64'd0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (x >= res + bit_v) begin
            x   = x - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // 2^-(2^-(k+1)) in Q0.32, by repeated truncated square roots of one half
   function automatic logic [31:0] root_at(input int k);
      logic [63:0] r;
      r = 64'h8000_0000;
      for (int j = 0; j <= k; j++) begin
         r = isqrt64(r << 32);
      end
      return r[31:0];
   endfunction

   localparam logic [31:0] ROOT_TAB [16] = '{
      root_at(0),  root_at(1),  root_at(2),  root_at(3),
      root_at(4),  root_at(5),  root_at(6),  root_at(7),
      root_at(8),  root_at(9),  root_at(10), root_at(11),
      root_at(12), root_at(13), root_at(14), root_at(15)
   };

endpackage

/* rtl/acs_mul.sv */
`timescale 1ns / 1ps
module acs_mul #(
   parameter int A_BITS = 33,
   parameter int B_BITS = 33
) (
   input  logic                       clock,
   input  logic [A_BITS-1:0]          mul_a,
   input  logic [B_BITS-1:0]          mul_b,
   output logic [A_BITS+B_BITS-1:0]   mul_p
);
   logic [A_BITS+B_BITS-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= (A_BITS+B_BITS)'(mul_a) * (A_BITS+B_BITS)'(mul_b);
   end

   assign mul_p = prod_ff;
endmodule

/* rtl/acs_ram.sv */
`timescale 1ns / 1ps
module acs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(DEPTH)-1:0]   waddr,
   input  logic [WIDTH-1:0]           wdata,
   input  logic [$clog2(DEPTH)-1:0]   raddr,
   output logic [WIDTH-1:0]           rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/ant_colony_next_city_step.sv */
`timescale 1ns / 1ps
// Ant Colony System transition step for one ant.
// Command channel: start with req_* fields is taken when busy is low. func selects load
// edge, start tour, step or read edge. Each transaction returns exactly one result on
// the rsp_* ports, valid for the single cycle in which rsp_strobe is high; the receiver
// cannot stall, and the result is never held. Configuration: csr_we, csr_index and
// csr_wdata write one register per cycle; the user writes only while idle (not enforced).
// Load and start go straight to the response state; read first waits on the edge store.
// A step scans the cities up to the city count and scores each reachable unvisited one;
// each score takes one root multiply per one bit in its exponent fraction and a final
// multiply unless its exponent is 48 or more or its root product is one. Roulette steps
// scan the cities again. The single shared multiplier carries the log2 squaring chain
// (16 passes), the root product chain and the pheromone scaling.
// One transaction at a time; busy stays high until its result is issued.
// Reset: after reset the edge store is swept to absent, one entry a cycle, over all
// MAX_CITIES*MAX_CITIES entries (4096 by default) with busy high; the tour is cleared
// and the registers take their reset values.
module ant_colony_next_city_step #(
   parameter int MAX_CITIES     = 64,
   parameter int WEIGHT_BITS    = 16,
   parameter int PHEROMONE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_from_city,
   input  logic [5:0]  req_to_city,
   input  logic        req_edge_present,
   input  logic [15:0] req_edge_weight,
   input  logic [31:0] req_edge_pheromone,
   input  logic [15:0] req_rand_mode,
   input  logic [15:0] req_rand_pick,
   output logic        rsp_strobe,
   output logic [5:0]  rsp_dest_city,
   output logic [21:0] rsp_tour_length,
   output logic [6:0]  rsp_steps_taken,
   output logic [1:0]  rsp_status,
   output logic        rsp_read_present,
   output logic [15:0] rsp_read_weight,
   output logic [31:0] rsp_read_pheromone,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import acs_pkg::*;

   localparam int W     = WEIGHT_BITS;
   localparam int P     = PHEROMONE_BITS;
   localparam int CB    = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
   localparam int DEPTH = MAX_CITIES * MAX_CITIES;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(MAX_CITIES + 1);
   localparam int EW    = 1 + W + P;
   localparam int MA    = (P > 33) ? P : 33;
   localparam int PW    = MA + 33;
   localparam int TW    = P + CB + 1;
   localparam int HW    = P + 2;
   localparam int LW    = 35;

   state_type state_ff, state_in;

   logic [15:0] thr_ff;
   logic [15:0] evap_ff;
   logic [7:0]  beta_ff;
   logic [31:0] tau0_ff;
   logic [6:0]  ccount_ff;

   logic [AW-1:0]         clr_ff, clr_in;
   logic [MAX_CITIES-1:0] visited_ff, visited_in;
   logic [MAX_CITIES-1:0] cand_ff, cand_in;
   logic [CB-1:0]         cur_ff, cur_in;
   logic [6:0]            moves_ff, moves_in;
   logic [21:0]           path_ff, path_in;
   logic                  active_ff, active_in;
   logic                  greedy_ff, greedy_in;
   logic [15:0]           rpick_ff, rpick_in;
   logic [1:0]            status_ff, status_in;
   logic                  rdp_ff, rdp_in;
   logic [15:0]           rdw_ff, rdw_in;
   logic [31:0]           rdt_ff, rdt_in;
   logic [CNTW-1:0]       idx_ff, idx_in;
   logic [W-1:0]          w_ff, w_in;
   logic [P-1:0]          tau_ff, tau_in;
   logic [31:0]           y_ff, y_in;
   logic [15:0]           frac_ff, frac_in;
   logic [4:0]            n_ff, n_in;
   logic [3:0]            k_ff, k_in;
   logic [8:0]            en_ff, en_in;
   logic [15:0]           f_ff, f_in;
   logic [32:0]           acc_ff, acc_in;
   logic [P-1:0]          score_ff, score_in;
   logic [P-1:0]          best_ff, best_in;
   logic [CB-1:0]         pick_ff, pick_in;
   logic                  found_ff, found_in;
   logic [TW-1:0]         total_ff, total_in;
   logic [TW-1:0]         target_ff, target_in;
   logic [TW-1:0]         cum_ff, cum_in;
   logic [HW-1:0]         hi_ff, hi_in;
   logic [LW-1:0]         lo_ff, lo_in;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [5:0]  rsp_city_ff;
   logic [21:0] rsp_len_ff;
   logic [6:0]  rsp_steps_ff;
   logic [1:0]  rsp_status_ff;
   logic        rsp_rdp_ff;
   logic [15:0] rsp_rdw_ff;
   logic [31:0] rsp_rdt_ff;

   logic          em_we;
   logic [AW-1:0] em_waddr, em_raddr;
   logic [EW-1:0] em_wdata, em_rdata;
   logic          sm_we;
   logic [CB-1:0] sm_raddr;
   logic [P-1:0]  sm_rdata;

   logic [MA-1:0] mul_a;
   logic [32:0]   mul_b;
   logic [PW-1:0] mul_p;

   logic [CB-1:0]   city_mod [64];
   logic [CB-1:0]   from_c, to_c, idx_c;
   logic [CNTW-1:0] cnt;
   logic            accept;
   logic            e_pres;
   logic [W-1:0]    e_w;
   logic [P-1:0]    e_tau;
   logic [31:0]     wn;
   logic [4:0]      msb;
   logic [16:0]     na;
   logic [AW-1:0]   cur_base;

   for (genvar g = 0; g < 64; g++) begin : g_mod
      assign city_mod[g] = CB'(g % MAX_CITIES);
   end

   assign from_c   = city_mod[req_from_city];
   assign to_c     = city_mod[req_to_city];
   assign idx_c    = idx_ff[CB-1:0];
   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign cnt      = (32'(ccount_ff) > 32'(MAX_CITIES)) ? CNTW'(MAX_CITIES) : CNTW'(ccount_ff);
   assign e_pres   = em_rdata[EW-1];
   assign e_w      = em_rdata[W+P-1:P];
   assign e_tau    = em_rdata[P-1:0];
   assign na       = 17'h1_0000 - 17'(evap_ff);
   assign cur_base = AW'(AW'(cur_ff) * AW'(MAX_CITIES));
   assign wn       = (w_ff == '0) ? 32'd1 : 32'(w_ff);

   always_comb begin
      msb = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (wn[i]) begin
            msb = 5'(i);
         end
      end
   end

   acs_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_edge_ram (
      .clock (clock),
      .we    (em_we),
      .waddr (em_waddr),
      .wdata (em_wdata),
      .raddr (em_raddr),
      .rdata (em_rdata)
   );

   acs_ram #(.WIDTH(P), .DEPTH(MAX_CITIES)) u_score_ram (
      .clock (clock),
      .we    (sm_we),
      .waddr (idx_c),
      .wdata (score_ff),
      .raddr (sm_raddr),
      .rdata (sm_rdata)
   );

   acs_mul #(.A_BITS(MA), .B_BITS(33)) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         thr_ff        <= RST_GREEDY;
         evap_ff       <= RST_EVAP;
         beta_ff       <= RST_BETA;
         tau0_ff       <= RST_TAU0;
         ccount_ff     <= RST_CITIES;
         visited_ff    <= '0;
         cur_ff        <= '0;
         moves_ff      <= '0;
         path_ff       <= '0;
         active_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         visited_ff    <= visited_in;
         cur_ff        <= cur_in;
         moves_ff      <= moves_in;
         path_ff       <= path_in;
         active_ff     <= active_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_GREEDY: thr_ff    <= csr_wdata[15:0];
               CSR_EVAP:   evap_ff   <= csr_wdata[15:0];
               CSR_BETA:   beta_ff   <= csr_wdata[7:0];
               CSR_TAU0:   tau0_ff   <= csr_wdata;
               CSR_CITIES: ccount_ff <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_ff   <= cand_in;
      greedy_ff <= greedy_in;
      rpick_ff  <= rpick_in;
      status_ff <= status_in;
      rdp_ff    <= rdp_in;
      rdw_ff    <= rdw_in;
      rdt_ff    <= rdt_in;
      idx_ff    <= idx_in;
      w_ff      <= w_in;
      tau_ff    <= tau_in;
      y_ff      <= y_in;
      frac_ff   <= frac_in;
      n_ff      <= n_in;
      k_ff      <= k_in;
      en_ff     <= en_in;
      f_ff      <= f_in;
      acc_ff    <= acc_in;
      score_ff  <= score_in;
      best_ff   <= best_in;
      pick_ff   <= pick_in;
      found_ff  <= found_in;
      total_ff  <= total_in;
      target_ff <= target_in;
      cum_ff    <= cum_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      if (rsp_strobe_in) begin
         rsp_city_ff   <= 6'(cur_ff);
         rsp_len_ff    <= path_ff;
         rsp_steps_ff  <= moves_ff;
         rsp_status_ff <= status_ff;
         rsp_rdp_ff    <= rdp_ff;
         rsp_rdw_ff    <= rdw_ff;
         rsp_rdt_ff    <= rdt_ff;
      end
   end

   always_comb begin
      logic [32:0]   sq;
      logic [24:0]   e_v;
      logic [TW-1:0] cum_new;
      logic [6:0]    sh;
      logic [HW+1:0] tau_sum;

      sq      = mul_p[63:31];
      e_v     = mul_p[28:4];
      cum_new = cum_ff + TW'(sm_rdata);
      sh      = 7'd16 + 7'(en_ff[5:0]);
      tau_sum = (HW+2)'(hi_ff) + (HW+2)'(lo_ff[LW-1:16]);

      state_in      = state_ff;
      clr_in        = clr_ff;
      visited_in    = visited_ff;
      cand_in       = cand_ff;
      cur_in        = cur_ff;
      moves_in      = moves_ff;
      path_in       = path_ff;
      active_in     = active_ff;
      greedy_in     = greedy_ff;
      rpick_in      = rpick_ff;
      status_in     = status_ff;
      rdp_in        = rdp_ff;
      rdw_in        = rdw_ff;
      rdt_in        = rdt_ff;
      idx_in        = idx_ff;
      w_in          = w_ff;
      tau_in        = tau_ff;
      y_in          = y_ff;
      frac_in       = frac_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      en_in         = en_ff;
      f_in          = f_ff;
      acc_in        = acc_ff;
      score_in      = score_ff;
      best_in       = best_ff;
      pick_in       = pick_ff;
      found_in      = found_ff;
      total_in      = total_ff;
      target_in     = target_ff;
      cum_in        = cum_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      rsp_strobe_in = 1'b0;

      em_we    = 1'b0;
      em_waddr = AW'(cur_base + AW'(pick_ff));
      em_wdata = {1'b1, w_ff, P'(tau_sum)};
      em_raddr = AW'(cur_base + AW'(idx_c));
      sm_we    = 1'b0;
      sm_raddr = idx_c;
      mul_a    = '0;
      mul_b    = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            em_we    = 1'b1;
            em_waddr = clr_ff;
            em_wdata = '0;
            if (32'(clr_ff) == DEPTH - 1) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            em_raddr = AW'(AW'(from_c) * AW'(MAX_CITIES) + AW'(to_c));
            if (accept) begin
               status_in = STAT_OK;
               rdp_in    = 1'b0;
               rdw_in    = '0;
               rdt_in    = '0;
               unique case (req_func)
                  FN_LOAD: begin
                     em_we    = 1'b1;
                     em_waddr = em_raddr;
                     em_wdata = {req_edge_present, W'(req_edge_weight), P'(req_edge_pheromone)};
                     state_in = ST_RESP;
                  end
                  FN_START: begin
                     visited_in        = '0;
                     visited_in[to_c]  = 1'b1;
                     cur_in            = to_c;
                     moves_in          = '0;
                     path_in           = '0;
                     active_in         = 1'b1;
                     state_in          = ST_RESP;
                  end
                  FN_READ: begin
                     state_in = ST_RD_WAIT;
                  end
                  default: begin
                     if (!active_ff) begin
                        status_in = STAT_NOSTART;
                        state_in  = ST_RESP;
                     end else begin
                        greedy_in = req_rand_mode < thr_ff;
                        rpick_in  = req_rand_pick;
                        idx_in    = '0;
                        found_in  = 1'b0;
                        total_in  = '0;
                        best_in   = '0;
                        pick_in   = '0;
                        cand_in   = '0;
                        state_in  = ST_SC_RD;
                     end
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            rdp_in   = e_pres;
            rdw_in   = 16'(e_w);
            rdt_in   = 32'(e_tau);
            state_in = ST_RESP;
         end
         ST_SC_RD: begin
            state_in = (idx_ff == cnt) ? ST_DECIDE : ST_SC_CHK;
         end
         ST_SC_CHK: begin
            if (e_pres && !visited_ff[idx_c]) begin
               cand_in[idx_c] = 1'b1;
               w_in           = e_w;
               tau_in         = e_tau;
               state_in       = ST_NORM;
            end else begin
               idx_in   = idx_ff + CNTW'(1);
               state_in = ST_SC_RD;
            end
         end
         ST_NORM: begin
            y_in     = wn << (5'd31 - msb);
            n_in     = msb;
            frac_in  = '0;
            k_in     = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            mul_a    = MA'(y_ff);
            mul_b    = 33'(y_ff);
            state_in = ST_SQW;
         end
         ST_SQW: begin
            frac_in = {frac_ff[14:0], sq[32]};
            y_in    = sq[32] ? sq[32:1] : sq[31:0];
            if (k_ff == 4'd15) begin
               state_in = ST_EXP;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = ST_SQ;
            end
         end
         ST_EXP: begin
            mul_a    = MA'({n_ff, frac_ff});
            mul_b    = 33'(beta_ff);
            state_in = ST_EXPW;
         end
         ST_EXPW: begin
            en_in    = e_v[24:16];
            f_in     = e_v[15:0];
            acc_in   = ONE_Q32;
            k_in     = '0;
            state_in = ST_RT;
         end
         ST_RT: begin
            if (f_ff[4'd15 - k_ff]) begin
               mul_a    = MA'(acc_ff);
               mul_b    = 33'(ROOT_TAB[k_ff]);
               state_in = ST_RTW;
            end else if (k_ff == 4'd15) begin
               state_in = ST_G;
            end else begin
               k_in = k_ff + 4'd1;
            end
         end
         ST_RTW: begin
            acc_in = mul_p[64:32];
            if (k_ff == 4'd15) begin
               state_in = ST_G;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = ST_RT;
            end
         end
         ST_G: begin
            if (en_ff >= 9'd48) begin
               score_in = '0;
               state_in = ST_SC_ADD;
            end else if (acc_ff[32]) begin
               score_in = tau_ff >> en_ff;
               state_in = ST_SC_ADD;
            end else begin
               mul_a    = MA'(tau_ff);
               mul_b    = 33'(acc_ff[32:16]);
               state_in = ST_GW;
            end
         end
         ST_GW: begin
            score_in = P'(mul_p >> sh);
            state_in = ST_SC_ADD;
         end
         ST_SC_ADD: begin
            sm_we    = 1'b1;
            total_in = total_ff + TW'(score_ff);
            if (!found_ff || score_ff > best_ff) begin
               best_in = score_ff;
               pick_in = idx_c;
            end
            found_in = 1'b1;
            idx_in   = idx_ff + CNTW'(1);
            state_in = ST_SC_RD;
         end
         ST_DECIDE: begin
            if (!found_ff) begin
               status_in = STAT_NONE;
               state_in  = ST_RESP;
            end else if (greedy_ff) begin
               state_in = ST_U_RD;
            end else begin
               state_in = ST_T1;
            end
         end
         ST_T1: begin
            mul_a    = MA'(total_ff[TW-1:16]);
            mul_b    = 33'(rpick_ff);
            state_in = ST_T2;
         end
         ST_T2: begin
            target_in = mul_p[TW-1:0];
            mul_a     = MA'(total_ff[15:0]);
            mul_b     = 33'(rpick_ff);
            state_in  = ST_T3;
         end
         ST_T3: begin
            target_in = target_ff + TW'(mul_p[PW-1:16]);
            idx_in    = '0;
            cum_in    = '0;
            state_in  = ST_RL_RD;
         end
         ST_RL_RD: begin
            state_in = (idx_ff == cnt) ? ST_U_RD : ST_RL_CHK;
         end
         ST_RL_CHK: begin
            if (cand_ff[idx_c]) begin
               pick_in = idx_c;
               cum_in  = cum_new;
               if (target_ff < cum_new) begin
                  state_in = ST_U_RD;
               end else begin
                  idx_in   = idx_ff + CNTW'(1);
                  state_in = ST_RL_RD;
               end
            end else begin
               idx_in   = idx_ff + CNTW'(1);
               state_in = ST_RL_RD;
            end
         end
         ST_U_RD: begin
            em_raddr = AW'(cur_base + AW'(pick_ff));
            state_in = ST_U_GET;
         end
         ST_U_GET: begin
            w_in     = e_w;
            tau_in   = e_tau;
            state_in = ST_U_M1;
         end
         ST_U_M1: begin
            mul_a    = MA'(tau_ff >> 16);
            mul_b    = 33'(na);
            state_in = ST_U_M2;
         end
         ST_U_M2: begin
            hi_in    = HW'(mul_p);
            mul_a    = MA'(tau0_ff[31:16]);
            mul_b    = 33'(evap_ff);
            state_in = ST_U_M3;
         end
         ST_U_M3: begin
            hi_in    = hi_ff + HW'(mul_p);
            mul_a    = MA'(tau_ff[15:0]);
            mul_b    = 33'(na);
            state_in = ST_U_M4;
         end
         ST_U_M4: begin
            lo_in    = LW'(mul_p);
            mul_a    = MA'(tau0_ff[15:0]);
            mul_b    = 33'(evap_ff);
            state_in = ST_U_M5;
         end
         ST_U_M5: begin
            lo_in    = lo_ff + LW'(mul_p);
            state_in = ST_U_WR;
         end
         ST_U_WR: begin
            em_we               = 1'b1;
            visited_in[pick_ff] = 1'b1;
            cur_in              = pick_ff;
            moves_in            = moves_ff + 7'd1;
            if (33'(w_ff) > 33'(LEN_MAX) - 33'(path_ff)) begin
               path_in = LEN_MAX;
            end else begin
               path_in = path_ff + 22'(w_ff);
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_dest_city      = rsp_city_ff;
   assign rsp_tour_length    = rsp_len_ff;
   assign rsp_steps_taken    = rsp_steps_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_present   = rsp_rdp_ff;
   assign rsp_read_weight    = rsp_rdw_ff;
   assign rsp_read_pheromone = rsp_rdt_ff;
endmodule

/* rtl/acs_checker.sv */
`timescale 1ns / 1ps
module acs_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_status,
   input logic        rsp_read_present,
   input logic [15:0] rsp_read_weight,
   input logic [31:0] rsp_read_pheromone
);
   import acs_pkg::*;

   // an accepted transaction leaves the block busy in the cycle after accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a transaction");

   a_no_strobe_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("result issued in the cycle after accept");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result issued while still busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status <= STAT_NOSTART))
      else $error("undefined status code");

   // errors only come from steps, which never carry read data
   a_err_no_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STAT_OK) |->
         (!rsp_read_present && rsp_read_weight == 16'd0 && rsp_read_pheromone == 32'd0))
      else $error("error result carries read data");
endmodule

bind ant_colony_next_city_step acs_checker u_acs_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import acs_pkg::*;

   typedef struct packed {
      logic [1:0]  func;
      logic [5:0]  from_city;
      logic [5:0]  to_city;
      logic        present;
      logic [15:0] weight;
      logic [31:0] pher;
      logic [15:0] q;
      logic [15:0] r;
   } cmd_type;

   typedef struct packed {
      logic [5:0]  dest_city;
      logic [21:0] tour_length;
      logic [6:0]  steps_taken;
      logic [1:0]  status;
      logic        read_present;
      logic [15:0] read_weight;
      logic [31:0] read_pheromone;
   } walk_type;

   typedef struct packed {
      cmd_type  cmd;
      logic     typed;
      walk_type res;
   } dir_row_type;

   logic        clock, reset, start, busy;
   logic [1:0]  req_func;
   logic [5:0]  req_from_city, req_to_city;
   logic        req_edge_present;
   logic [15:0] req_edge_weight, req_rand_mode, req_rand_pick;
   logic [31:0] req_edge_pheromone;
   logic        rsp_strobe;
   logic [5:0]  rsp_dest_city;
   logic [21:0] rsp_tour_length;
   logic [6:0]  rsp_steps_taken;
   logic [1:0]  rsp_status;
   logic        rsp_read_present;
   logic [15:0] rsp_read_weight;
   logic [31:0] rsp_read_pheromone;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   ant_colony_next_city_step u_dut (.*);

   // model of the colony state
   bit               edge_on [4096];
   bit [15:0]        edge_len [4096];
   bit [31:0]        edge_tau [4096];
   bit               seen [64];
   bit [5:0]         here;
   bit [6:0]         moves;
   bit [21:0]        walked;
   bit               on_tour;
   bit [15:0]        q0, rate;
   bit [7:0]         beta;
   bit [31:0]        tau0;
   bit [6:0]         ncities;
   longint unsigned  half_roots [16];

   walk_type walk_expected [$];
   int    fails;
   int    items;
   int    burst_left;
   int    idle_count;

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned acc, b;
      acc = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= acc + b) begin
            x = x - (acc + b);
            acc = (acc >> 1) + b;
         end else begin
            acc = acc >> 1;
         end
         b = b >> 2;
      end
      return acc;
   endfunction

   function automatic longint unsigned log2_fix(input longint unsigned w);
      int unsigned n;
      longint unsigned y, fr;
      n = 0;
      fr = 0;
      if (w == 0) w = 1;
      while (n < 31 && (w >> (n + 1)) != 0) n++;
      y = w << (31 - n);
      for (int k = 0; k < 16; k++) begin
         y = (y * y) >> 31;
         fr = fr << 1;
         if (y >= 64'h1_0000_0000) begin
            fr = fr | 1;
            y = y >> 1;
         end
      end
      return (longint'(n) << 16) | fr;
   endfunction

   function automatic longint unsigned edge_score(input int idx);
      longint unsigned e, n, f, acc, g, tau;
      e = (longint'(beta) * log2_fix(edge_len[idx])) >> 4;
      n = e >> 16;
      f = e & 16'hFFFF;
      acc = 64'h1_0000_0000;
      tau = edge_tau[idx];
      for (int k = 0; k < 16; k++)
         if ((f >> (15 - k)) & 1) acc = (acc * half_roots[k]) >> 32;
      g = acc >> 16;
      if (n >= 48) return 0;
      if (g >= 65536) return tau >> n;
      return (tau * g) >> (16 + n);
   endfunction

   function automatic walk_type colony_step(input cmd_type c);
      walk_type o;
      int base, pick, idx, lim;
      bit found;
      longint unsigned best, total, s, target, cum, hi, lo, na, w;
      o = '0;
      idx = c.from_city * 64 + c.to_city;
      lim = (ncities > 64) ? 64 : ncities;
      case (c.func)
         FN_LOAD: begin
            edge_on[idx] = c.present;
            edge_len[idx] = c.weight;
            edge_tau[idx] = c.pher;
         end
         FN_START: begin
            foreach (seen[i]) seen[i] = 0;
            seen[c.to_city] = 1;
            here = c.to_city;
            moves = 0;
            walked = 0;
            on_tour = 1;
         end
         FN_READ: begin
            o.read_present = edge_on[idx];
            o.read_weight = edge_len[idx];
            o.read_pheromone = edge_tau[idx];
         end
         default: begin
            if (!on_tour) begin
               o.status = STAT_NOSTART;
            end else begin
               base = here * 64;
               found = 0;
               best = 0;
               total = 0;
               pick = 0;
               for (int i = 0; i < lim; i++) begin
                  if (!edge_on[base + i] || seen[i]) continue;
                  s = edge_score(base + i);
                  if (!found || s > best) begin
                     best = s;
                     pick = i;
                  end
                  found = 1;
                  total += s;
               end
               if (!found) begin
                  o.status = STAT_NONE;
               end else begin
                  if (!(c.q < q0)) begin
                     target = (total >> 16) * c.r + (((total & 16'hFFFF) * c.r) >> 16);
                     cum = 0;
                     for (int i = 0; i < lim; i++) begin
                        if (!edge_on[base + i] || seen[i]) continue;
                        pick = i;
                        cum += edge_score(base + i);
                        if (target < cum) break;
                     end
                  end
                  idx = base + pick;
                  seen[pick] = 1;
                  here = pick;
                  moves = moves + 1;
                  w = edge_len[idx];
                  if (w > longint'(LEN_MAX) - walked) walked = LEN_MAX;
                  else walked = walked + w;
                  na = 65536 - rate;
                  hi = (edge_tau[idx] >> 16) * na + (tau0 >> 16) * rate;
                  lo = (edge_tau[idx] & 16'hFFFF) * na + (tau0 & 16'hFFFF) * rate;
                  edge_tau[idx] = hi + (lo >> 16);
               end
            end
         end
      endcase
      o.dest_city = here;
      o.tour_length = walked;
      o.steps_taken = moves;
      return o;
   endfunction

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= 60000) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic check_field(input string name, input longint unsigned e,
                              input longint unsigned a);
      if (e != a) begin
         $error("%s: expected %0h, got %0h", name, e, a);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      walk_type e;
      if (!reset && rsp_strobe) begin
         if (walk_expected.size() == 0) begin
            $error("unexpected transaction on result port");
            fails++;
         end else begin
            e = walk_expected.pop_front();
            check_field("dest_city", e.dest_city, rsp_dest_city);
            check_field("tour_length", e.tour_length, rsp_tour_length);
            check_field("steps_taken", e.steps_taken, rsp_steps_taken);
            check_field("status", e.status, rsp_status);
            check_field("read_present", e.read_present, rsp_read_present);
            check_field("read_weight", e.read_weight, rsp_read_weight);
            check_field("read_pheromone", e.read_pheromone, rsp_read_pheromone);
         end
      end
   end

   task automatic send(input cmd_type c, input bit typed, input walk_type want);
      walk_type p;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      burst_left--;
      do @(negedge clock); while (busy);
      req_func <= c.func;
      req_from_city <= c.from_city;
      req_to_city <= c.to_city;
      req_edge_present <= c.present;
      req_edge_weight <= c.weight;
      req_edge_pheromone <= c.pher;
      req_rand_mode <= c.q;
      req_rand_pick <= c.r;
      start <= 1;
      @(posedge clock);
      p = colony_step(c);
      walk_expected.push_back(typed ? want : p);
      items++;
      @(negedge clock);
      start <= 0;
   endtask

   task automatic drain();
      while (walk_expected.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_GREEDY: q0 = val[15:0];
         CSR_EVAP:   rate = val[15:0];
         CSR_BETA:   beta = val[7:0];
         CSR_TAU0:   tau0 = val;
         CSR_CITIES: ncities = val[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 0;
   endtask

   function automatic logic [31:0] pick_val(input logic [31:0] top);
      case ($urandom_range(0, 3))
         0: return 0;
         1: return top;
         default: return $urandom() & top;
      endcase
   endfunction

   function automatic cmd_type rand_cmd(input logic [1:0] f, input int hi_city);
      cmd_type c;
      c.func = f;
      c.from_city = $urandom_range(0, hi_city);
      c.to_city = $urandom_range(0, hi_city);
      c.present = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 9))
         0: c.weight = 0;
         1: c.weight = 16'hFFFF;
         2, 3, 4, 5: c.weight = $urandom_range(1, 16);
         default: c.weight = $urandom();
      endcase
      case ($urandom_range(0, 7))
         0: c.pher = 0;
         1: c.pher = 32'hFFFF_FFFF;
         default: c.pher = $urandom();
      endcase
      c.q = $urandom();
      c.r = $urandom();
      return c;
   endfunction

   dir_row_type dir_tab [$];

   initial begin
      int ph, nodes, eff;
      logic [6:0] cnt;
      cmd_type c;
      fails = 0;
      items = 0;
      burst_left = 0;
      idle_count = 0;
      reset = 1;
      start = 0;
      req_func = FN_LOAD;
      req_from_city = 0;
      req_to_city = 0;
      req_edge_present = 0;
      req_edge_weight = 0;
      req_edge_pheromone = 0;
      req_rand_mode = 0;
      req_rand_pick = 0;
      csr_we = 0;
      csr_index = CSR_GREEDY;
      csr_wdata = 0;
      q0 = RST_GREEDY;
      rate = RST_EVAP;
      beta = RST_BETA;
      tau0 = RST_TAU0;
      ncities = RST_CITIES;
      begin
         longint unsigned rr;
         rr = 64'h8000_0000;
         for (int k = 0; k < 16; k++) begin
            rr = int_sqrt(rr << 32);
            half_roots[k] = rr;
         end
      end

      dir_tab = '{
         '{'{FN_READ, 6'd0, 6'd0, 1'b0, 16'd0, 32'd0, 16'd0, 16'd0}, 1'b1,
           '{6'd0, 22'd0, 7'd0, STAT_OK, 1'b0, 16'd0, 32'd0}},
         '{'{FN_STEP, 6'd0, 6'd0, 1'b0, 16'd0, 32'd0, 16'hFFFF, 16'd0}, 1'b1,
           '{6'd0, 22'd0, 7'd0, STAT_NOSTART, 1'b0, 16'd0, 32'd0}},
         '{'{FN_LOAD, 6'd0, 6'd1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 16'd0, 16'd0}, 1'b1,
           '{6'd0, 22'd0, 7'd0, STAT_OK, 1'b0, 16'd0, 32'd0}},
         '{'{FN_READ, 6'd0, 6'd1, 1'b0, 16'd0, 32'd0, 16'd0, 16'd0}, 1'b1,
           '{6'd0, 22'd0, 7'd0, STAT_OK, 1'b1, 16'hFFFF, 32'hFFFF_FFFF}},
         '{'{FN_LOAD, 6'd63, 6'd62, 1'b1, 16'd1, 32'd0, 16'd0, 16'd0}, 1'b1,
           '{6'd0, 22'd0, 7'd0, STAT_OK, 1'b0, 16'd0, 32'd0}},
         '{'{FN_READ, 6'd63, 6'd62, 1'b0, 16'd0, 32'd0, 16'd0, 16'd0}, 1'b1,
           '{6'd0, 22'd0, 7'd0, STAT_OK, 1'b1, 16'd1, 32'd0}},
         '{'{FN_LOAD, 6'd0, 6'd2, 1'b1, 16'd0, 32'h1_0000, 16'd0, 16'd0}, 1'b0, '0},
         '{'{FN_LOAD, 6'd0, 6'd3, 1'b0, 16'd7, 32'd5, 16'd0, 16'd0}, 1'b0, '0},
         '{'{FN_LOAD, 6'd2, 6'd3, 1'b1, 16'd3, 32'h8000_0000, 16'd0, 16'd0}, 1'b0, '0},
         '{'{FN_START, 6'd0, 6'd0, 1'b0, 16'd0, 32'd0, 16'd0, 16'd0}, 1'b1,
           '{6'd0, 22'd0, 7'd0, STAT_OK, 1'b0, 16'd0, 32'd0}},
         '{'{FN_STEP, 6'd0, 6'd0, 1'b0, 16'd0, 32'd0, 16'hFFFF, 16'd0}, 1'b0, '0},
         '{'{FN_STEP, 6'd0, 6'd0, 1'b0, 16'd0, 32'd0, 16'd0, 16'hFFFF}, 1'b0, '0},
         '{'{FN_STEP, 6'd0, 6'd0, 1'b0, 16'd0, 32'd0, 16'h8000, 16'h8000}, 1'b0, '0},
         '{'{FN_START, 6'd0, 6'd63, 1'b0, 16'd0, 32'd0, 16'd0, 16'd0}, 1'b1,
           '{6'd63, 22'd0, 7'd0, STAT_OK, 1'b0, 16'd0, 32'd0}},
         '{'{FN_STEP, 6'd0, 6'd0, 1'b0, 16'd0, 32'd0, 16'hFFFF, 16'hFFFF}, 1'b1,
           '{6'd62, 22'd1, 7'd1, STAT_OK, 1'b0, 16'd0, 32'd0}},
         // nothing leaves city 62
         '{'{FN_STEP, 6'd0, 6'd0, 1'b0, 16'd0, 32'd0, 16'd0, 16'd0}, 1'b1,
           '{6'd62, 22'd1, 7'd1, STAT_NONE, 1'b0, 16'd0, 32'd0}},
         '{'{FN_READ, 6'd63, 6'd62, 1'b0, 16'd0, 32'd0, 16'd0, 16'd0}, 1'b0, '0},
         '{'{FN_START, 6'd0, 6'd5, 1'b0, 16'd0, 32'd0, 16'd0, 16'd0}, 1'b1,
           '{6'd5, 22'd0, 7'd0, STAT_OK, 1'b0, 16'd0, 32'd0}},
         '{'{FN_STEP, 6'd0, 6'd0, 1'b0, 16'd0, 32'd0, 16'd1, 16'd1}, 1'b1,
           '{6'd5, 22'd0, 7'd0, STAT_NONE, 1'b0, 16'd0, 32'd0}}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (dir_tab[i]) send(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].res);

      ph = 0;
      while (items < 1450) begin
         // hold the sender until every transaction has answered, then reprogram
         drain();
         case (ph)
            0: cnt = 2;
            1: cnt = 64;
            2: cnt = 127;
            3: cnt = 1;
            4: cnt = 0;
            default: cnt = $urandom_range(3, 10);
         endcase
         csr_write(CSR_GREEDY, pick_val(32'hFFFF));
         csr_write(CSR_EVAP, pick_val(32'hFFFF));
         csr_write(CSR_BETA, pick_val(32'hFF));
         csr_write(CSR_TAU0, pick_val(32'hFFFF_FFFF));
         csr_write(CSR_CITIES, cnt);
         eff = (cnt > 64) ? 64 : cnt;
         nodes = (eff < 2) ? 2 : eff;
         if (nodes <= 12) begin
            for (int i = 0; i < nodes; i++)
               for (int j = 0; j < nodes; j++)
                  if ($urandom_range(0, 3) != 0) begin
                     c = rand_cmd(FN_LOAD, 63);
                     c.from_city = i;
                     c.to_city = j;
                     send(c, 1'b0, '0);
                  end
         end else begin
            repeat (120) send(rand_cmd(FN_LOAD, 63), 1'b0, '0);
         end
         repeat ($urandom_range(2, 4)) begin
            c = rand_cmd(FN_START, nodes - 1);
            if ($urandom_range(0, 9) == 0) c.to_city = $urandom_range(0, 63);
            send(c, 1'b0, '0);
            repeat (((nodes > 12) ? 6 : nodes) + 1) begin
               case ($urandom_range(0, 19))
                  0: send(rand_cmd(FN_READ, nodes - 1), 1'b0, '0);
                  1: send(rand_cmd(FN_LOAD, 63), 1'b0, '0);
                  default: ;
               endcase
               send(rand_cmd(FN_STEP, 63), 1'b0, '0);
            end
         end
         repeat (6) send(rand_cmd(FN_READ, 63), 1'b0, '0);
         ph++;
      end

      drain();
      repeat (20) @(posedge clock);
      if (fails == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/acs_pkg.sv
rtl/acs_mul.sv
rtl/acs_ram.sv
rtl/ant_colony_next_city_step.sv
rtl/acs_checker.sv
verif/testbench.sv
